// File: rtl/jbcp_pkg.sv
// Package for the jagged block core partitioner.
// Holds widths, configuration register indexes, item types, controller states,
// datapath commands and the controller/datapath status struct. No dependencies.
package jbcp_pkg;

  // Field and internal widths.
  localparam int OFF_W      = 24;
  localparam int CORE_W     = 7;
  localparam int IDX_W      = 6;
  localparam int BL_W       = 11;
  localparam int HEAD_W     = 7;
  localparam int CNT_W      = 21;
  localparam int COST_W     = 22;
  localparam int POS_W      = 37;
  localparam int BLK_W      = 36;
  localparam int LOAD_W     = 56;
  localparam int SUM_W      = 64;
  localparam int P1_W       = 43;
  localparam int P2_W       = 49;
  localparam int DIVN_W     = 65;
  localparam int OFFN_W     = 25;
  localparam int DIV_CNT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Default sizes handed to the top level parameters.
  localparam int MAX_SEQUENCES_DEF = 1024;
  localparam int MAX_CORES_DEF     = 64;

  // Saturation limit of a stored block count.
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAUSAL_MODE = 2'd3;

  // Configuration reset values.
  localparam logic [CORE_W-1:0] CORE_COUNT_RST = 7'd48;
  localparam logic [BL_W-1:0]   BLOCK_LEN_RST  = 11'd128;
  localparam logic [HEAD_W-1:0] HEAD_COUNT_RST = 7'd1;
  localparam logic              CAUSAL_RST     = 1'b1;

  typedef struct packed {
    logic [OFF_W-1:0] seq_offset;
    logic             last_offset;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  core_index;
    logic [BLK_W-1:0]  start_block;
    logic [BLK_W-1:0]  end_block;
    logic [LOAD_W-1:0] core_load;
    logic              last_core;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OFF_DIV,
    ST_STORE,
    ST_AFTER,
    ST_SUM_INIT,
    ST_SUM_CHK,
    ST_SUM_RD,
    ST_SUM_MUL1,
    ST_SUM_MUL2,
    ST_SUM_ACC,
    ST_LIM_LOAD,
    ST_LIM_DIV,
    ST_WALK_INIT,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_CORE_START,
    ST_TAKE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_STEP,
    OP_STORE,
    OP_SUM_INIT,
    OP_SUM_RD,
    OP_SUM_MUL1,
    OP_SUM_MUL2,
    OP_SUM_ACC,
    OP_LIM_LOAD,
    OP_WALK_INIT,
    OP_LOAD_RD,
    OP_LOAD_WR,
    OP_CORE_START,
    OP_TAKE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic start_seen;
    logic last;
    logic div_last;
    logic sum_more;
    logic can_walk;
    logic take_ok;
    logic need_load;
    logic out_free;
    logic last_core;
  } status_t;

endpackage

// File: rtl/jbcp_stream_if.sv
// Valid/ready stream interface used for the offset and result channels.
// The payload type is a parameter; types come from jbcp_pkg.
interface jbcp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/jagged_block_core_partitioner.sv
// Top level of the jagged block core partitioner.
// Joins the controller and the datapath; uses jbcp_pkg and jbcp_stream_if.
//
//   Channel   Direction  Content
//   in_ch     sink       seq_offset, last_offset
//   out_ch    source     core_index, start_block, end_block, core_load, last_core
//   cfg_*     input      write enable, register index, write data
//
// A start offset is only recorded; every later offset also runs through the
// 25-step bit-serial divider that forms its block count, and a nonzero count is stored.
// On the last offset the work sum reads the store and uses two multipliers per
// sequence, then the limit division runs, and the walk takes blocks one at a
// time, with a store reload per sequence and a start and an emit per core.
// Reset is synchronous; no clearing pass is needed. A stalled result holds the
// walk in place until it is taken.
module jagged_block_core_partitioner #(
  parameter int MAX_SEQUENCES = jbcp_pkg::MAX_SEQUENCES_DEF,
  parameter int MAX_CORES     = jbcp_pkg::MAX_CORES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jbcp_stream_if.sink                     in_ch,
  jbcp_stream_if.source                   out_ch,
  input  logic                            cfg_we,
  input  logic [jbcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jbcp_pkg::CFG_DATA_W-1:0] cfg_data
);

  jbcp_pkg::cmd_t      cmd;
  jbcp_pkg::status_t   status;
  jbcp_pkg::in_item_t  in_item;
  jbcp_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  // Channel payload mapping.
  assign in_item       = in_ch.data;
  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.data   = out_item;

  jbcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  jbcp_datapath #(
    .MAX_SEQUENCES (MAX_SEQUENCES),
    .MAX_CORES     (MAX_CORES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_item),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: rtl/jbcp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module jbcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: rtl/jbcp_ctrl.sv
// Controller state machine of the partitioner: sequences offset intake, the
// work sum, the limit division and the per-core walk. Uses jbcp_pkg.
module jbcp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jbcp_pkg::status_t status,
  output jbcp_pkg::cmd_t    cmd
);

  jbcp_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jbcp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = jbcp_pkg::OP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      jbcp_pkg::ST_IDLE: begin
        // No transfer is taken while reset is held.
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.op    = jbcp_pkg::OP_ACCEPT;
          state_nxt = status.start_seen ? jbcp_pkg::ST_OFF_DIV : jbcp_pkg::ST_AFTER;
        end
      end
      jbcp_pkg::ST_OFF_DIV: begin
        cmd.op = jbcp_pkg::OP_DIV_STEP;
        if (status.div_last) begin
          state_nxt = jbcp_pkg::ST_STORE;
        end
      end
      jbcp_pkg::ST_STORE: begin
        cmd.op    = jbcp_pkg::OP_STORE;
        state_nxt = jbcp_pkg::ST_AFTER;
      end
      jbcp_pkg::ST_AFTER: begin
        state_nxt = status.last ? jbcp_pkg::ST_SUM_INIT : jbcp_pkg::ST_IDLE;
      end
      jbcp_pkg::ST_SUM_INIT: begin
        cmd.op    = jbcp_pkg::OP_SUM_INIT;
        state_nxt = jbcp_pkg::ST_SUM_CHK;
      end
      jbcp_pkg::ST_SUM_CHK: begin
        state_nxt = status.sum_more ? jbcp_pkg::ST_SUM_RD : jbcp_pkg::ST_LIM_LOAD;
      end
      jbcp_pkg::ST_SUM_RD: begin
        cmd.op    = jbcp_pkg::OP_SUM_RD;
        state_nxt = jbcp_pkg::ST_SUM_MUL1;
      end
      jbcp_pkg::ST_SUM_MUL1: begin
        cmd.op    = jbcp_pkg::OP_SUM_MUL1;
        state_nxt = jbcp_pkg::ST_SUM_MUL2;
      end
      jbcp_pkg::ST_SUM_MUL2: begin
        cmd.op    = jbcp_pkg::OP_SUM_MUL2;
        state_nxt = jbcp_pkg::ST_SUM_ACC;
      end
      jbcp_pkg::ST_SUM_ACC: begin
        cmd.op    = jbcp_pkg::OP_SUM_ACC;
        state_nxt = jbcp_pkg::ST_SUM_CHK;
      end
      jbcp_pkg::ST_LIM_LOAD: begin
        cmd.op    = jbcp_pkg::OP_LIM_LOAD;
        state_nxt = jbcp_pkg::ST_LIM_DIV;
      end
      jbcp_pkg::ST_LIM_DIV: begin
        cmd.op = jbcp_pkg::OP_DIV_STEP;
        if (status.div_last) begin
          state_nxt = jbcp_pkg::ST_WALK_INIT;
        end
      end
      jbcp_pkg::ST_WALK_INIT: begin
        cmd.op    = jbcp_pkg::OP_WALK_INIT;
        state_nxt = status.can_walk ? jbcp_pkg::ST_INIT_RD : jbcp_pkg::ST_CORE_START;
      end
      jbcp_pkg::ST_INIT_RD: begin
        cmd.op    = jbcp_pkg::OP_LOAD_RD;
        state_nxt = jbcp_pkg::ST_INIT_WR;
      end
      jbcp_pkg::ST_INIT_WR: begin
        cmd.op    = jbcp_pkg::OP_LOAD_WR;
        state_nxt = jbcp_pkg::ST_CORE_START;
      end
      jbcp_pkg::ST_CORE_START: begin
        cmd.op    = jbcp_pkg::OP_CORE_START;
        state_nxt = jbcp_pkg::ST_TAKE;
      end
      jbcp_pkg::ST_TAKE: begin
        if (status.take_ok) begin
          cmd.op    = jbcp_pkg::OP_TAKE;
          state_nxt = status.need_load ? jbcp_pkg::ST_LOAD_RD : jbcp_pkg::ST_TAKE;
        end else begin
          state_nxt = jbcp_pkg::ST_EMIT;
        end
      end
      jbcp_pkg::ST_LOAD_RD: begin
        cmd.op    = jbcp_pkg::OP_LOAD_RD;
        state_nxt = jbcp_pkg::ST_LOAD_WR;
      end
      jbcp_pkg::ST_LOAD_WR: begin
        cmd.op    = jbcp_pkg::OP_LOAD_WR;
        state_nxt = jbcp_pkg::ST_TAKE;
      end
      jbcp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.op    = jbcp_pkg::OP_EMIT;
          state_nxt = status.last_core ? jbcp_pkg::ST_IDLE : jbcp_pkg::ST_CORE_START;
        end
      end
      default: begin
        state_nxt = jbcp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/jbcp_datapath.sv
// Datapath of the partitioner: configuration registers, block count store,
// shared restoring divider, work sum multipliers, walk registers and the
// output register. Uses jbcp_pkg and jbcp_ram.
module jbcp_datapath #(
  parameter int MAX_SEQUENCES = jbcp_pkg::MAX_SEQUENCES_DEF,
  parameter int MAX_CORES     = jbcp_pkg::MAX_CORES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [jbcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jbcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  jbcp_pkg::in_item_t                  in_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output jbcp_pkg::out_item_t                 out_data,
  input  jbcp_pkg::cmd_t                      cmd,
  output jbcp_pkg::status_t                   status
);

  localparam int SCW = $clog2(MAX_SEQUENCES + 1);
  localparam int AW  = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam int OFF_PAD = jbcp_pkg::DIVN_W - jbcp_pkg::OFFN_W;

  // Configuration registers.
  logic [jbcp_pkg::CORE_W-1:0] core_count_r;
  logic [jbcp_pkg::BL_W-1:0]   block_len_r;
  logic [jbcp_pkg::HEAD_W-1:0] head_count_r;
  logic                        causal_r;

  // Intake and sum state.
  logic [jbcp_pkg::OFF_W-1:0]     prev_off_r;
  logic                           start_seen_r;
  logic                           last_r;
  logic [SCW-1:0]                 seq_cnt_r;
  logic [SCW-1:0]                 sum_idx_r;
  logic [jbcp_pkg::SUM_W-1:0]     total_r;
  logic [jbcp_pkg::P1_W-1:0]      p1_r;
  logic [jbcp_pkg::P2_W-1:0]      p2_r;

  // Divider state.
  logic [jbcp_pkg::DIVN_W-1:0]    q_r;
  logic [jbcp_pkg::BL_W-1:0]      rem_r;
  logic [jbcp_pkg::BL_W-1:0]      divisor_r;
  logic [jbcp_pkg::DIV_CNT_W-1:0] div_cnt_r;

  // Walk state.
  logic [jbcp_pkg::SUM_W-1:0]     limit_r;
  logic [SCW-1:0]                 seq_r;
  logic [jbcp_pkg::HEAD_W-1:0]    head_r;
  logic [jbcp_pkg::CNT_W-1:0]     rem_blk_r;
  logic [jbcp_pkg::CNT_W-1:0]     cur_n_r;
  logic [jbcp_pkg::COST_W-1:0]    next_cost_r;
  logic [jbcp_pkg::POS_W-1:0]     pos_r;
  logic [jbcp_pkg::POS_W-1:0]     start_r;
  logic [jbcp_pkg::SUM_W-1:0]     run_r;
  logic [jbcp_pkg::CORE_W-1:0]    core_r;
  logic                           active_r;
  logic                           had_r;

  // Output register.
  logic                           out_valid_r;
  jbcp_pkg::out_item_t            out_data_r;

  // RAM connections.
  logic                           ram_we;
  logic [AW-1:0]                  ram_raddr;
  logic [jbcp_pkg::CNT_W-1:0]     ram_rdata;

  // Combinational helpers.
  logic [jbcp_pkg::OFF_W-1:0]     diff;
  logic [jbcp_pkg::BL_W-1:0]      bl_eff;
  logic [jbcp_pkg::OFFN_W-1:0]    off_num;
  logic [jbcp_pkg::BL_W:0]        rem_shift;
  logic                           q_bit;
  logic [jbcp_pkg::CNT_W-1:0]     n_sat;
  logic                           store_ok;
  logic [jbcp_pkg::CORE_W-1:0]    cores_eff;
  logic [jbcp_pkg::COST_W-1:0]    mul_m;
  logic [jbcp_pkg::P1_W-2:0]      half_p1;
  logic [jbcp_pkg::COST_W-1:0]    blk_cost;
  logic                           head_wrap;
  logic                           seq_end;
  logic                           take_ok;
  logic                           out_free;
  logic                           last_core;
  logic [jbcp_pkg::POS_W-1:0]     end_pos;

  // Offset difference and rounded-up numerator for the block count.
  always_comb begin
    diff    = (in_data.seq_offset >= prev_off_r) ? (in_data.seq_offset - prev_off_r) : '0;
    bl_eff  = (block_len_r == '0) ? jbcp_pkg::BL_W'(1) : block_len_r;
    off_num = jbcp_pkg::OFFN_W'(diff) + jbcp_pkg::OFFN_W'(bl_eff) - jbcp_pkg::OFFN_W'(1);
  end

  // One restoring division step.
  always_comb begin
    rem_shift = {rem_r, q_r[jbcp_pkg::DIVN_W-1]};
    q_bit     = (rem_shift >= {1'b0, divisor_r});
  end

  // Saturated block count from the offset quotient.
  always_comb begin
    n_sat    = (|q_r[jbcp_pkg::OFFN_W-1:jbcp_pkg::CNT_W]) ? jbcp_pkg::COUNT_MAX
             : q_r[jbcp_pkg::CNT_W-1:0];
    store_ok = (n_sat != '0) && (seq_cnt_r < SCW'(MAX_SEQUENCES));
  end

  // Core count clamped to the supported range.
  always_comb begin
    if (core_count_r == '0) begin
      cores_eff = jbcp_pkg::CORE_W'(1);
    end else if (core_count_r > jbcp_pkg::CORE_W'(MAX_CORES)) begin
      cores_eff = jbcp_pkg::CORE_W'(MAX_CORES);
    end else begin
      cores_eff = core_count_r;
    end
  end

  // Segment cost factors.
  always_comb begin
    mul_m   = causal_r ? ({1'b0, ram_rdata} + jbcp_pkg::COST_W'(1)) : {1'b0, ram_rdata};
    half_p1 = causal_r ? p1_r[jbcp_pkg::P1_W-1:1] : p1_r[jbcp_pkg::P1_W-2:0];
  end

  // Walk decisions.
  always_comb begin
    blk_cost  = causal_r ? next_cost_r : {1'b0, cur_n_r};
    head_wrap = ((head_r + jbcp_pkg::HEAD_W'(1)) >= head_count_r);
    seq_end   = (({1'b0, seq_r} + (SCW + 1)'(1)) >= {1'b0, seq_cnt_r});
    take_ok   = active_r && (run_r < limit_r);
    out_free  = !out_valid_r || out_ready;
    last_core = ((core_r + jbcp_pkg::CORE_W'(1)) == cores_eff);
    end_pos   = had_r ? pos_r : '0;
  end

  // Status to the controller.
  always_comb begin
    status.start_seen = start_seen_r;
    status.last       = last_r;
    status.div_last   = (div_cnt_r == jbcp_pkg::DIV_CNT_W'(1));
    status.sum_more   = (sum_idx_r < seq_cnt_r);
    status.can_walk   = (seq_cnt_r != '0) && (head_count_r != '0);
    status.take_ok    = take_ok;
    status.need_load  = (rem_blk_r == jbcp_pkg::CNT_W'(1)) && head_wrap && !seq_end;
    status.out_free   = out_free;
    status.last_core  = last_core;
  end

  // Block count store.
  assign ram_we    = (cmd.op == jbcp_pkg::OP_STORE) && store_ok;
  assign ram_raddr = (cmd.op == jbcp_pkg::OP_SUM_RD) ? sum_idx_r[AW-1:0] : seq_r[AW-1:0];

  jbcp_ram #(
    .WIDTH (jbcp_pkg::CNT_W),
    .DEPTH (MAX_SEQUENCES)
  ) u_counts (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (seq_cnt_r[AW-1:0]),
    .wdata   (n_sat),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_count_r <= jbcp_pkg::CORE_COUNT_RST;
      block_len_r  <= jbcp_pkg::BLOCK_LEN_RST;
      head_count_r <= jbcp_pkg::HEAD_COUNT_RST;
      causal_r     <= jbcp_pkg::CAUSAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jbcp_pkg::CFG_CORE_COUNT:  core_count_r <= cfg_data[jbcp_pkg::CORE_W-1:0];
        jbcp_pkg::CFG_BLOCK_LEN:   block_len_r  <= cfg_data;
        jbcp_pkg::CFG_HEAD_COUNT:  head_count_r <= cfg_data[jbcp_pkg::HEAD_W-1:0];
        jbcp_pkg::CFG_CAUSAL_MODE: causal_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control registers of the intake and walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_seen_r <= 1'b0;
      seq_cnt_r    <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        jbcp_pkg::OP_ACCEPT: start_seen_r <= 1'b1;
        jbcp_pkg::OP_STORE: begin
          if (store_ok) begin
            seq_cnt_r <= seq_cnt_r + SCW'(1);
          end
        end
        jbcp_pkg::OP_WALK_INIT: active_r <= (seq_cnt_r != '0) && (head_count_r != '0);
        jbcp_pkg::OP_TAKE: begin
          if ((rem_blk_r == jbcp_pkg::CNT_W'(1)) && head_wrap && seq_end) begin
            active_r <= 1'b0;
          end
        end
        jbcp_pkg::OP_EMIT: begin
          out_valid_r <= 1'b1;
          if (last_core) begin
            seq_cnt_r    <= '0;
            start_seen_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      jbcp_pkg::OP_ACCEPT: begin
        prev_off_r <= in_data.seq_offset;
        last_r     <= in_data.last_offset;
        q_r        <= {off_num, {OFF_PAD{1'b0}}};
        rem_r      <= '0;
        divisor_r  <= bl_eff;
        div_cnt_r  <= jbcp_pkg::DIV_CNT_W'(jbcp_pkg::OFFN_W);
      end
      jbcp_pkg::OP_LIM_LOAD: begin
        q_r       <= {1'b0, total_r} + jbcp_pkg::DIVN_W'(cores_eff) - jbcp_pkg::DIVN_W'(1);
        rem_r     <= '0;
        divisor_r <= jbcp_pkg::BL_W'(cores_eff);
        div_cnt_r <= jbcp_pkg::DIV_CNT_W'(jbcp_pkg::DIVN_W);
      end
      jbcp_pkg::OP_DIV_STEP: begin
        rem_r     <= q_bit ? jbcp_pkg::BL_W'(rem_shift - {1'b0, divisor_r})
                           : rem_shift[jbcp_pkg::BL_W-1:0];
        q_r       <= {q_r[jbcp_pkg::DIVN_W-2:0], q_bit};
        div_cnt_r <= div_cnt_r - jbcp_pkg::DIV_CNT_W'(1);
      end
      jbcp_pkg::OP_SUM_INIT: begin
        total_r   <= '0;
        sum_idx_r <= '0;
      end
      jbcp_pkg::OP_SUM_MUL1: p1_r <= jbcp_pkg::P1_W'(ram_rdata * mul_m);
      jbcp_pkg::OP_SUM_MUL2: p2_r <= jbcp_pkg::P2_W'(half_p1 * head_count_r);
      jbcp_pkg::OP_SUM_ACC: begin
        total_r   <= total_r + jbcp_pkg::SUM_W'(p2_r);
        sum_idx_r <= sum_idx_r + SCW'(1);
      end
      jbcp_pkg::OP_WALK_INIT: begin
        limit_r <= q_r[jbcp_pkg::SUM_W-1:0];
        seq_r   <= '0;
        head_r  <= '0;
        pos_r   <= '0;
        core_r  <= '0;
      end
      jbcp_pkg::OP_LOAD_WR: begin
        cur_n_r     <= ram_rdata;
        rem_blk_r   <= ram_rdata;
        next_cost_r <= jbcp_pkg::COST_W'(1);
      end
      jbcp_pkg::OP_CORE_START: begin
        run_r   <= '0;
        had_r   <= active_r;
        start_r <= active_r ? pos_r : '0;
      end
      jbcp_pkg::OP_TAKE: begin
        run_r       <= run_r + jbcp_pkg::SUM_W'(blk_cost);
        pos_r       <= pos_r + jbcp_pkg::POS_W'(1);
        next_cost_r <= next_cost_r + jbcp_pkg::COST_W'(1);
        rem_blk_r   <= rem_blk_r - jbcp_pkg::CNT_W'(1);
        if (rem_blk_r == jbcp_pkg::CNT_W'(1)) begin
          if (head_wrap) begin
            head_r <= '0;
            seq_r  <= seq_r + SCW'(1);
          end else begin
            // Next head repeats the same segment.
            head_r      <= head_r + jbcp_pkg::HEAD_W'(1);
            rem_blk_r   <= cur_n_r;
            next_cost_r <= jbcp_pkg::COST_W'(1);
          end
        end
      end
      jbcp_pkg::OP_EMIT: begin
        out_data_r.core_index  <= core_r[jbcp_pkg::IDX_W-1:0];
        out_data_r.start_block <= start_r[jbcp_pkg::POS_W-1] ? '1
                                : start_r[jbcp_pkg::BLK_W-1:0];
        out_data_r.end_block   <= end_pos[jbcp_pkg::POS_W-1] ? '1
                                : end_pos[jbcp_pkg::BLK_W-1:0];
        out_data_r.core_load   <= (|run_r[jbcp_pkg::SUM_W-1:jbcp_pkg::LOAD_W]) ? '1
                                : run_r[jbcp_pkg::LOAD_W-1:0];
        out_data_r.last_core   <= last_core;
        core_r                 <= core_r + jbcp_pkg::CORE_W'(1);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for jagged_block_core_partitioner.
// Uses jbcp_pkg and jbcp_stream_if from the rtl folder. Items are checked
// against an in-bench partition predictor.
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [jbcp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [jbcp_pkg::CFG_DATA_W-1:0] cfg_data;

  jbcp_stream_if #(.payload_t(jbcp_pkg::in_item_t)) in_if ();
  jbcp_stream_if #(.payload_t(jbcp_pkg::out_item_t)) out_if ();

  jagged_block_core_partitioner dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 40;
  localparam longint unsigned BLOCK_SAT = 64'hF_FFFF_FFFF;
  localparam longint unsigned LOAD_SAT  = 64'hFF_FFFF_FFFF_FFFF;

  // Offsets waiting to be driven and core results waiting to be seen.
  jbcp_pkg::in_item_t  pending_offsets[$];
  jbcp_pkg::out_item_t expected_cores[$];
  int        fail_count;
  int        sender_idle_pct;
  int        receiver_stall_pct;
  int        hold_left;
  int        quiet_cycles;

  // Predictor state and its copy of the registers.
  bit [6:0]  pr_cores;
  bit [10:0] pr_block_len;
  bit [6:0]  pr_heads;
  bit        pr_causal;
  bit [23:0] pr_prev_offset;
  bit        pr_start_seen;
  longint unsigned seq_blocks[$];

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Cost of k causal blocks whose first block costs t.
  function automatic longint unsigned causal_cost(longint unsigned k, longint unsigned t);
    return k * t + k * (k - 1) / 2;
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned m);
    return v > m ? m : v;
  endfunction

  // Splits the stored blocks among the cores and queues one result per core.
  function automatic void partition_cores();
    longint unsigned cores, total, limit, next_cost, remaining, position, load;
    longint unsigned first, stop, need, k, lo, hi, mid, c;
    int seq, head;
    bit active;
    jbcp_pkg::out_item_t r;
    cores = pr_cores == 0 ? 1 : (pr_cores > 64 ? 64 : pr_cores);
    total = 0;
    foreach (seq_blocks[i]) begin
      c = seq_blocks[i];
      total += pr_heads * (pr_causal ? c * (c + 1) / 2 : c * c);
    end
    limit = (total + cores - 1) / cores;
    active = seq_blocks.size() > 0 && pr_heads > 0;
    next_cost = 1;
    seq = 0;
    head = 0;
    position = 0;
    remaining = active ? seq_blocks[0] : 0;
    for (longint unsigned core = 0; core < cores; core++) begin
      first = 0;
      stop = 0;
      load = 0;
      if (active) begin
        first = position;
        while (active && load < limit) begin
          need = limit - load;
          if (pr_causal) begin
            lo = 1;
            hi = remaining;
            if (causal_cost(remaining, next_cost) < need) begin
              lo = remaining;
            end else begin
              while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (causal_cost(mid, next_cost) >= need) hi = mid;
                else lo = mid + 1;
              end
            end
            k = lo;
            load += causal_cost(k, next_cost);
          end else begin
            c = seq_blocks[seq];
            k = (need + c - 1) / c;
            if (k > remaining) k = remaining;
            load += k * c;
          end
          position += k;
          remaining -= k;
          next_cost += k;
          if (remaining == 0) begin
            head++;
            if (head >= pr_heads) begin
              head = 0;
              seq++;
            end
            if (seq >= seq_blocks.size()) begin
              active = 0;
            end else begin
              remaining = seq_blocks[seq];
              next_cost = 1;
            end
          end
        end
        stop = position;
      end
      r.core_index  = core[5:0];
      r.start_block = jbcp_pkg::BLK_W'(clip(first, BLOCK_SAT));
      r.end_block   = jbcp_pkg::BLK_W'(clip(stop, BLOCK_SAT));
      r.core_load   = jbcp_pkg::LOAD_W'(clip(load, LOAD_SAT));
      r.last_core   = (core + 1 == cores);
      expected_cores.push_back(r);
    end
    seq_blocks.delete();
    pr_start_seen = 0;
  endfunction

  // Closes a sequence on each offset after the start; the marked offset runs the partition.
  function automatic void take_offset(jbcp_pkg::in_item_t it);
    longint unsigned diff, len, n;
    if (pr_start_seen) begin
      diff = it.seq_offset >= pr_prev_offset ? it.seq_offset - pr_prev_offset : 0;
      len = pr_block_len == 0 ? 1 : pr_block_len;
      n = (diff + len - 1) / len;
      if (n > 64'h1F_FFFF) n = 64'h1F_FFFF;
      if (n != 0 && seq_blocks.size() < 1024) seq_blocks.push_back(n);
    end
    pr_prev_offset = it.seq_offset;
    pr_start_seen = 1;
    if (it.last_offset) partition_cores();
  endfunction

  // Offset driver: a new item goes out once the current one has transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) take_offset(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (pending_offsets.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_if.data  <= pending_offsets.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer and drives random or long stalls.
  always @(posedge clk) begin
    jbcp_pkg::out_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_cores.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, out_if.data);
          fail_count++;
        end else begin
          want = expected_cores.pop_front();
          if (want !== out_if.data) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_if.data);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= $urandom_range(99) >= receiver_stall_pct;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Presents one register write; the next edge performs it.
  task automatic write_reg(logic [jbcp_pkg::CFG_IDX_W-1:0] idx,
                           logic [jbcp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      jbcp_pkg::CFG_CORE_COUNT:  pr_cores = val[6:0];
      jbcp_pkg::CFG_BLOCK_LEN:   pr_block_len = val;
      jbcp_pkg::CFG_HEAD_COUNT:  pr_heads = val[6:0];
      jbcp_pkg::CFG_CAUSAL_MODE: pr_causal = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int cores, int len, int heads, int causal);
    write_reg(jbcp_pkg::CFG_CORE_COUNT, jbcp_pkg::CFG_DATA_W'(cores));
    write_reg(jbcp_pkg::CFG_BLOCK_LEN, jbcp_pkg::CFG_DATA_W'(len));
    write_reg(jbcp_pkg::CFG_HEAD_COUNT, jbcp_pkg::CFG_DATA_W'(heads));
    write_reg(jbcp_pkg::CFG_CAUSAL_MODE, jbcp_pkg::CFG_DATA_W'(causal));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_offset(int off, bit last);
    jbcp_pkg::in_item_t it;
    it.seq_offset  = jbcp_pkg::OFF_W'(off);
    it.last_offset = last;
    pending_offsets.push_back(it);
  endtask

  // Waits until every offset and every result has transferred.
  task automatic drain();
    while (pending_offsets.size() > 0 || in_if.valid || expected_cores.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sent, round, groups, count, off, len;
    fail_count = 0;
    quiet_cycles = 0;
    hold_left = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    pr_cores = jbcp_pkg::CORE_COUNT_RST;
    pr_block_len = jbcp_pkg::BLOCK_LEN_RST;
    pr_heads = jbcp_pkg::HEAD_COUNT_RST;
    pr_causal = jbcp_pkg::CAUSAL_RST;
    pr_prev_offset = '0;
    pr_start_seen = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a lone start with the last mark leaves every core idle,
    // then empty, backward and ordinary sequences.
    push_offset(0, 1);
    push_offset(0, 0);
    push_offset(300, 0);
    push_offset(300, 0);
    push_offset(100, 0);
    push_offset(1000, 1);
    drain();

    // Widest offset span with a block length of 1024, on one core.
    set_regs(1, 1024, 1, 1);
    push_offset(0, 0);
    push_offset(24'hFFFFFF, 1);
    drain();

    // Core count above range clamps; no heads leaves every core idle.
    set_regs(127, 16, 0, 0);
    push_offset(5, 0);
    push_offset(900, 1);
    drain();

    // Zero block length acts as one; core count zero clamps to one.
    set_regs(0, 0, 3, 1);
    push_offset(0, 0);
    push_offset(5, 0);
    push_offset(9, 1);
    drain();

    // Most cores, with 64 heads and full cost.
    set_regs(64, 16, 64, 0);
    push_offset(0, 0);
    push_offset(40, 0);
    push_offset(100, 1);
    drain();
    sent = 16;

    // Random rounds: well-formed offset runs under changing settings.
    round = 0;
    while (sent < 330) begin
      case (round % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
        default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
      endcase
      len = $urandom_range(9) == 0 ? 1024 : $urandom_range(16, 1024);
      set_regs($urandom_range(9) == 0 ? 64 : $urandom_range(1, 64), len,
               $urandom_range(7) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 8),
               $urandom_range(1));
      // Long receiver hold while offsets keep coming, so the input stalls.
      if (round == 2) hold_left = 400;
      groups = (round == 2) ? 4 : $urandom_range(1, 4);
      repeat (groups) begin
        count = $urandom_range(1, 8);
        off = $urandom_range(0, 24'hFFFFFF);
        for (int i = 0; i < count; i++) begin
          if (i > 0) begin
            if ($urandom_range(9) == 0) off -= $urandom_range(0, 500);
            else off += len * $urandom_range(0, 8) + $urandom_range(0, len);
            if (off < 0) off = 0;
            if (off > 24'hFFFFFF) off = 24'hFFFFFF;
          end
          push_offset(off, i == count - 1);
          sent++;
        end
      end
      drain();
      round++;
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: jagged_block_core_partitioner.f
rtl/jbcp_pkg.sv
rtl/jbcp_stream_if.sv
rtl/jbcp_ram.sv
rtl/jbcp_ctrl.sv
rtl/jbcp_datapath.sv
rtl/jagged_block_core_partitioner.sv
bench/tb_top.sv
